[src/ccps_pkg.sv]
package ccps_pkg;

	localparam logic [1:0] CMD_TOOTH  = 2'd0;
	localparam logic [1:0] CMD_CAM    = 2'd1;
	localparam logic [1:0] CMD_RESYNC = 2'd2;

	localparam logic [2:0] REG_FIRING  = 3'd0;
	localparam logic [2:0] REG_WINDOW  = 3'd1;
	localparam logic [2:0] REG_CONFIRM = 3'd2;
	localparam logic [2:0] REG_EXP_B1I = 3'd3;
	localparam logic [2:0] REG_EXP_B1E = 3'd4;
	localparam logic [2:0] REG_EXP_B2I = 3'd5;
	localparam logic [2:0] REG_EXP_B2E = 3'd6;

	localparam logic [1:0] LEVEL_LOST    = 2'd0;
	localparam logic [1:0] LEVEL_PARTIAL = 2'd1;
	localparam logic [1:0] LEVEL_FULL    = 2'd2;

	localparam logic [20:0] SPEED_NUM = 21'd1666667;
	localparam int unsigned DIV_STEPS = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILT,
		ST_EVENT,
		ST_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic div_step;
		logic filt;
		logic apply;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tooth;
		logic need_div;
		logic div_last;
	} dp_status_t;

endpackage

[src/ccps_ctrl.sv]
module ccps_ctrl
	import ccps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		out_valid_d = out_valid_q;
		if (out_valid_q && !out_stall) out_valid_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.is_tooth && status.need_div) begin
					cmd.div_step = 1'b1;
					if (status.div_last) state_d = ST_FILT;
				end else begin
					state_d = ST_EVENT;
				end
			end
			ST_FILT: begin
				cmd.filt = 1'b1;
				state_d  = ST_EVENT;
			end
			ST_EVENT: begin
				cmd.apply = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The result register is only overwritten once its transfer is done.
	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n)
			(out_valid_q && out_stall) |-> !cmd.load_out;
	endproperty
	a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

	property p_busy_stall;
		@(posedge clk) disable iff (!arst_n)
			cmd.capture |=> in_stall;
	endproperty
	a_busy_stall: assert property (p_busy_stall) else $error("input taken while busy");

	property p_load_valid;
		@(posedge clk) disable iff (!arst_n)
			cmd.load_out |=> out_valid;
	endproperty
	a_load_valid: assert property (p_load_valid) else $error("result not presented");

endmodule

[src/ccps_datapath.sv]
module ccps_datapath
	import ccps_pkg::*;
#(
	parameter int CYLINDERS     = 8,
	parameter int CAMS          = 4,
	parameter int TOOTH_DEGREES = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic [1:0]         cmd_in,
	input  logic [5:0]         tooth_number,
	input  logic [31:0]        event_time,
	input  logic [1:0]         cam_select,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	output logic [9:0]         cycle_angle,
	output logic [31:0]        tooth_period,
	output logic [20:0]        speed_raw,
	output logic [20:0]        speed_filtered,
	output logic [1:0]         sync_level,
	output logic               phase_locked,
	output logic [2:0]         cylinder_now,
	output logic [2:0]         cylinder_next,
	output logic signed [8:0]  cam_phase,
	output logic [31:0]        lock_count
);

	localparam int SLOT_W = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;

	// Configuration registers.
	logic [23:0] firing_q;
	logic [7:0]  window_q;
	logic [3:0]  confirm_need_q;
	logic [8:0]  expect_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			firing_q       <= 24'd5652360;
			window_q       <= 8'd30;
			confirm_need_q <= 4'd2;
			expect_q[0]    <= 9'd25;
			expect_q[1]    <= 9'd185;
			expect_q[2]    <= 9'd205;
			expect_q[3]    <= 9'd15;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRING:  firing_q       <= cfg_data;
				REG_WINDOW:  window_q       <= cfg_data[7:0];
				REG_CONFIRM: confirm_need_q <= cfg_data[3:0];
				REG_EXP_B1I: expect_q[0]    <= cfg_data[8:0];
				REG_EXP_B1E: expect_q[1]    <= cfg_data[8:0];
				REG_EXP_B2I: expect_q[2]    <= cfg_data[8:0];
				REG_EXP_B2E: expect_q[3]    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Captured item.
	logic [1:0]  icmd_q;
	logic [5:0]  itooth_q;
	logic [31:0] itime_q;
	logic [1:0]  icam_q;

	// Engine state.
	logic [31:0] last_time_q, last_period_q, total_q;
	logic        seen_q, phase_ok_q, phase_upper_q, cand_q;
	logic [5:0]  tooth_q;
	logic [20:0] raw_q, smooth_q;
	logic [1:0]  sync_q;
	logic [3:0]  run_q;
	logic [SLOT_W-1:0] slot_q;
	logic [2:0]  cyl_q;
	logic signed [8:0] phase_q;

	// Divider registers: restoring, one quotient bit per resolving step.
	logic [31:0] div_d_q;
	logic [20:0] div_n_q;
	logic [31:0] div_r_q;
	logic [20:0] div_qt_q;
	logic [5:0]  div_cnt_q;

	logic [31:0] period_new;
	assign period_new = seen_q ? (itime_q - last_time_q) : 32'd0;

	assign status.is_tooth = (icmd_q == CMD_TOOTH);
	assign status.need_div = (period_new != 32'd0);
	assign status.div_last = (div_cnt_q == 6'(DIV_STEPS - 1));

	// Cylinder of a firing slot; the slot is at most one past the last one.
	function automatic logic [2:0] cyl_at(input logic [23:0] tab, input logic [3:0] s);
		logic [3:0] w;
		logic [4:0] sh;
		w  = (int'(s) >= CYLINDERS) ? 4'd0 : s;
		sh = 5'(3 * w);
		return 3'(tab >> sh);
	endfunction

	// Angle within a revolution.
	logic [9:0]  angle_now;
	logic [10:0] tooth_deg, ang_w;
	assign tooth_deg = 11'(tooth_q * TOOTH_DEGREES);
	always_comb begin
		ang_w = tooth_deg;
		if (ang_w >= 11'd1440) ang_w = ang_w - 11'd1440;
		if (ang_w >= 11'd720) ang_w = ang_w - 11'd720;
		if (ang_w >= 11'd360) ang_w = ang_w - 11'd360;
		angle_now = ang_w[9:0];
	end

	// Cam deviation, wrapped.
	logic signed [10:0] dev;
	logic [10:0] mag;
	always_comb begin
		dev = $signed({1'b0, angle_now}) - $signed({2'b00, expect_q[icam_q]});
		if (dev > 11'sd180) dev = dev - 11'sd360;
		if (dev < -11'sd180) dev = dev + 11'sd360;
		mag = dev[10] ? 11'(-dev) : 11'(dev);
	end

	logic [32:0] trial;
	assign trial = {div_r_q, div_n_q[20]} - {1'b0, div_d_q};

	logic [22:0] filt_sum;
	assign filt_sum = 23'(smooth_q) * 23'd3 + 23'(div_qt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0; last_period_q <= '0; total_q <= '0;
			seen_q <= 1'b0; phase_ok_q <= 1'b0; phase_upper_q <= 1'b0; cand_q <= 1'b0;
			tooth_q <= '0; raw_q <= '0; smooth_q <= '0; sync_q <= LEVEL_LOST;
			run_q <= '0; slot_q <= '0; cyl_q <= '0; phase_q <= '0;
			div_cnt_q <= '0; div_d_q <= '0; div_n_q <= '0; div_r_q <= '0;
			div_qt_q <= '0;
		end else begin
			if (cmd.capture) begin
				div_cnt_q <= '0;
				div_r_q   <= '0;
				div_n_q   <= SPEED_NUM;
				div_qt_q  <= '0;
			end
			// Division: the divisor loads on the first step and the last 21 steps
			// each resolve one quotient bit.
			if (cmd.div_step) begin
				if (div_cnt_q == 6'd0) div_d_q <= period_new;
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_cnt_q >= 6'(DIV_STEPS - 21) && div_cnt_q != 6'd0) begin
					if (!trial[32]) begin
						div_r_q  <= trial[31:0];
						div_qt_q <= {div_qt_q[19:0], 1'b1};
					end else begin
						div_r_q  <= {div_r_q[30:0], div_n_q[20]};
						div_qt_q <= {div_qt_q[19:0], 1'b0};
					end
					div_n_q <= {div_n_q[19:0], 1'b0};
				end
			end
			if (cmd.filt) begin
				// The quotient is complete: it becomes the raw speed and feeds the filter.
				raw_q    <= div_qt_q;
				smooth_q <= 21'(filt_sum >> 2);
			end
			if (cmd.apply) begin
				phase_q <= (icmd_q == CMD_CAM && 32'(icam_q) < CAMS) ? 9'(dev) : 9'sd0;
				unique case (icmd_q)
					CMD_TOOTH: begin
						logic [1:0] sm;
						sm = sync_q;
						last_time_q   <= itime_q;
						seen_q        <= 1'b1;
						last_period_q <= period_new;
						tooth_q       <= itooth_q;
						if (phase_ok_q && sm == LEVEL_PARTIAL) begin
							sm = LEVEL_FULL;
							total_q <= total_q + 32'd1;
						end
						if (itooth_q == 6'd0 && sm == LEVEL_FULL) begin
							slot_q <= (32'(slot_q) + 1 >= CYLINDERS) ? '0 : slot_q + 1'b1;
							cyl_q  <= cyl_at(firing_q, 4'(slot_q) + 4'd1);
						end
						if (itooth_q == 6'd0 && sm == LEVEL_LOST) sm = LEVEL_PARTIAL;
						sync_q <= sm;
					end
					CMD_CAM: begin
						if (32'(icam_q) < CAMS) begin
							if (icam_q == 2'd0 && !phase_ok_q) begin
								if (mag > 11'(window_q)) begin
									run_q <= '0;
								end else if (run_q == 4'd0 || (angle_now > 10'd180) != cand_q) begin
									cand_q <= (angle_now > 10'd180);
									run_q  <= 4'd1;
								end else if (run_q + 4'd1 >= confirm_need_q) begin
									phase_upper_q <= cand_q;
									phase_ok_q    <= 1'b1;
									run_q         <= '0;
								end else begin
									run_q <= run_q + 4'd1;
								end
							end
						end
					end
					CMD_RESYNC: begin
						sync_q <= LEVEL_LOST; phase_ok_q <= 1'b0;
						raw_q <= '0; smooth_q <= '0; cyl_q <= '0; slot_q <= '0;
						phase_upper_q <= 1'b0; run_q <= '0; cand_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// Captured item and result registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			icmd_q   <= cmd_in;
			itooth_q <= tooth_number;
			itime_q  <= event_time;
			icam_q   <= cam_select;
		end
		if (cmd.load_out) begin
			cycle_angle    <= angle_now + ((phase_ok_q && phase_upper_q) ? 10'd360 : 10'd0);
			tooth_period   <= last_period_q;
			speed_raw      <= raw_q;
			speed_filtered <= smooth_q;
			sync_level     <= sync_q;
			phase_locked   <= phase_ok_q;
			cylinder_now   <= cyl_q;
			cylinder_next  <= cyl_at(firing_q, 4'(slot_q) + 4'd1);
			cam_phase      <= phase_q;
			lock_count     <= total_q;
		end
	end

endmodule

[src/crank_cam_position_sync.sv]
// Crank and cam position decoder for a 36-2 crank wheel.
// Input channel (in_valid/in_stall): one item per transfer, cmd selects a
// crank tooth, a cam edge or a resync. Output channel (out_valid/out_stall):
// exactly one status result per input item, in order.
// A crank tooth with a nonzero period passes ST_DIV, where the 32-step
// bit-serial speed divider runs, then ST_FILT, ST_EVENT and ST_OUT; any
// other item passes ST_DIV, ST_EVENT and ST_OUT. One item is in work at a
// time; the next transfer can follow in the cycle after the result loads.
// in_stall is high while an item is in work.
// The result sits in an output register; a stalled receiver holds it and the
// next item is worked on meanwhile, waiting only to load its own result.
// The user writes the plain configuration port (cfg_we, cfg_index, cfg_data)
// only while idle; the block does not enforce it. Reset (arst_n low) restores
// the register defaults and clears all engine state; no clearing pass is needed.
module crank_cam_position_sync
	import ccps_pkg::*;
#(
	parameter int CYLINDERS     = 8,
	parameter int CAMS          = 4,
	parameter int TOOTH_DEGREES = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [5:0]        tooth_number,
	input  logic [31:0]       event_time,
	input  logic [1:0]        cam_select,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [9:0]        cycle_angle,
	output logic [31:0]       tooth_period,
	output logic [20:0]       speed_raw,
	output logic [20:0]       speed_filtered,
	output logic [1:0]        sync_level,
	output logic              phase_locked,
	output logic [2:0]        cylinder_now,
	output logic [2:0]        cylinder_next,
	output logic signed [8:0] cam_phase,
	output logic [31:0]       lock_count
);

	dp_cmd_t    dcmd;
	dp_status_t dstat;

	ccps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.status(dstat), .cmd(dcmd)
	);

	ccps_datapath #(
		.CYLINDERS(CYLINDERS), .CAMS(CAMS), .TOOTH_DEGREES(TOOTH_DEGREES)
	) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.cmd_in(cmd), .tooth_number, .event_time, .cam_select,
		.cmd(dcmd), .status(dstat),
		.cycle_angle, .tooth_period, .speed_raw, .speed_filtered, .sync_level,
		.phase_locked, .cylinder_now, .cylinder_next, .cam_phase, .lock_count
	);

endmodule
